/* sv/ascsp_pkg.sv */
// Shared types and constants for the ASCII-command stepper pulse generator.
// Item structs, parse phases, register indexes and the half-period divide constants.
// No dependencies.
`default_nettype none

package ascsp_pkg;

    // Motor count default and fixed field widths
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int OUT_LINES       = 4;
    localparam int HP_W            = 13;
    localparam int SPEED_W         = 14;
    localparam int CFG_IDX_W       = 1;

    // Reset values and limits
    localparam logic [HP_W-1:0]    FAST_RESET   = 13'd20;
    localparam logic [HP_W-1:0]    SLOW_RESET   = 13'd6000;
    localparam logic [HP_W-1:0]    DEFAULT_HALF = 13'd5000;
    localparam logic [HP_W-1:0]    ELAPSED_MAX  = 13'h1FFF;
    localparam logic [SPEED_W-1:0] SPEED_FULL   = 14'd1000;

    // Frame characters
    localparam logic [7:0] FRAME_END  = 8'h7C;
    localparam logic [7:0] DASH       = 8'h2D;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // Floor divide by 1000: bias the signed product positive by a multiple of
    // 1000, drop three bits (divide by 8), then multiply by ceil(2^28/125).
    localparam logic signed [24:0] DIV_BIAS    = 25'sd8192000;
    localparam logic [21:0]        RECIP_125   = 22'd2147484;
    localparam int                 RECIP_SHIFT = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FASTEST = 1'b0,
        CFG_SLOWEST = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_SIGN    = 3'd1,
        PH_DASHED  = 3'd2,
        PH_DIG2    = 3'd3,
        PH_DIG3    = 3'd4,
        PH_DIG4    = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [OUT_LINES-1:0] step_lines;
        logic [OUT_LINES-1:0] dir_lines;
        logic [OUT_LINES-1:0] enable_lines_n;
        logic                 frame_applied;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/ascii_command_stepper_pulse_gen_top.sv */
// Stepper pulse generator top level: frame parser, motor tick logic, half-period unit.
// Input and result are registered; one item per cycle sustained while out_stall is low.
// A tick that directly follows a speed-applying byte waits while the
// registered half-period divide finishes. Depends on ascsp_pkg.
// Reset (rst_n, async, active low): parser idle, motors off, dir normal, half-period 5000.
`default_nettype none

module ascii_command_stepper_pulse_gen_top
#(
    parameter int MOTOR_COUNT = ascsp_pkg::MOTOR_COUNT_DEF
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  ascsp_pkg::in_item_t             in_item,
    output logic                            out_valid,
    input  wire                             out_stall,
    output ascsp_pkg::out_item_t            out_item,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [ascsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ascsp_pkg::HP_W-1:0]       cfg_data
);

    import ascsp_pkg::*;

    localparam int              TGT_W     = $clog2(MOTOR_COUNT + 1);
    localparam logic [3:0]      MAX_DIGIT = 4'(MOTOR_COUNT);

    // Configuration registers
    logic [HP_W-1:0] fast_reg;
    logic [HP_W-1:0] slow_reg;

    // Input and output stage
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      process;

    // Parser state
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TGT_W-1:0]     target_reg;
    logic                 reverse_reg;
    logic [SPEED_W-1:0]   accum_reg;

    // Motor state
    logic [MOTOR_COUNT-1:0] enabled_reg;
    logic [MOTOR_COUNT-1:0] enabled_next;
    logic [MOTOR_COUNT-1:0] dir_reg;
    logic [MOTOR_COUNT-1:0] dir_next;
    logic [MOTOR_COUNT-1:0] step_reg;
    logic [MOTOR_COUNT-1:0] step_next;
    logic [HP_W-1:0]        hp_reg      [MOTOR_COUNT];
    logic [HP_W-1:0]        elapsed_reg [MOTOR_COUNT];
    logic [HP_W-1:0]        elapsed_next[MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] sel_mask;

    // Half-period unit
    logic                   pend_reg;
    logic [23:0]            prod_reg;
    logic [MOTOR_COUNT-1:0] mask_reg;

    // Decode
    logic         is_byte;
    logic         is_tick;
    logic         is_digit;
    logic [3:0]   dval;
    logic         capture_motor;
    logic         set_reverse;
    logic         shift_digit;
    logic         apply;
    logic [SPEED_W-1:0] accum_shift;
    logic [SPEED_W-1:0] speed;
    logic [9:0]         speed_gap;
    logic signed [13:0] hp_diff;
    logic signed [24:0] hp_prod;
    logic signed [24:0] hp_biased;
    logic [20:0]        div_in;
    logic [42:0]        div_prod;
    logic [HP_W-1:0]    hp_new;

    // Handshake: input register acts as the skid stage
    always_comb
    begin
        process = in_valid_reg && (!out_valid_reg || !out_stall)
                  && !(pend_reg && (in_item_reg.operation == OP_TICK));
    end

    assign in_stall  = in_valid_reg && !process;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Byte decode
    always_comb
    begin
        is_byte  = process && (in_item_reg.operation == OP_BYTE);
        is_tick  = process && (in_item_reg.operation == OP_TICK);
        is_digit = (in_item_reg.rx_byte >= DIGIT_ZERO) && (in_item_reg.rx_byte <= DIGIT_NINE);
        dval     = is_digit ? 4'(in_item_reg.rx_byte - DIGIT_ZERO) : 4'd0;
    end

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if (is_digit && (dval <= MAX_DIGIT))
                        phase_next = PH_SIGN;
                end
                PH_SIGN:
                begin
                    if (in_item_reg.rx_byte == DASH)
                        phase_next = PH_DASHED;
                    else if (is_digit)
                        phase_next = PH_DIG2;
                end
                PH_DASHED:
                begin
                    if (is_digit)
                        phase_next = PH_DIG2;
                end
                PH_DIG2:
                begin
                    if (is_digit)
                        phase_next = PH_DIG3;
                end
                PH_DIG3:
                begin
                    if (is_digit)
                        phase_next = PH_DIG4;
                end
                PH_DIG4:
                begin
                    if (is_digit)
                        phase_next = PH_DISCARD;
                end
                PH_DISCARD:
                begin
                    if (in_item_reg.rx_byte == FRAME_END)
                        phase_next = PH_SEEK;
                end
                default:
                    phase_next = PH_SEEK;
            endcase
        end
    end

    // Parser actions
    always_comb
    begin
        capture_motor = is_byte && (phase_reg == PH_SEEK) && is_digit && (dval <= MAX_DIGIT);
        set_reverse   = is_byte && (phase_reg == PH_SIGN) && (in_item_reg.rx_byte == DASH);
        shift_digit   = is_byte && is_digit
                        && (phase_reg != PH_SEEK) && (phase_reg != PH_DISCARD);
        apply         = shift_digit && (phase_reg == PH_DIG4);
        accum_shift   = SPEED_W'({accum_reg, 3'b000} + {accum_reg, 1'b0} + {10'd0, dval});
        speed         = (accum_shift > SPEED_FULL) ? SPEED_FULL : accum_shift;
        speed_gap     = 10'(SPEED_FULL - speed);
    end

    // Half-period stage one: signed product (slowest - fastest) * (1000 - speed)
    always_comb
    begin
        hp_diff   = $signed({1'b0, slow_reg}) - $signed({1'b0, fast_reg});
        hp_prod   = 25'(hp_diff) * 25'($signed({1'b0, speed_gap}));
        hp_biased = hp_prod + DIV_BIAS;
    end

    // Half-period stage two: floor divide by 1000; the bias of 8192 quotients
    // vanishes modulo 2^13, so only the low quotient bits are added.
    always_comb
    begin
        div_in   = prod_reg[23:3];
        div_prod = 43'(div_in) * 43'(RECIP_125);
        hp_new   = fast_reg + div_prod[RECIP_SHIFT+HP_W-1:RECIP_SHIFT];
    end

    // Motor updates for this item
    always_comb
    begin
        logic [HP_W-1:0] inc;
        logic            toggle;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            sel_mask[i]     = (target_reg == '0) || (target_reg == TGT_W'(i + 1));
            enabled_next[i] = enabled_reg[i];
            dir_next[i]     = dir_reg[i];
            step_next[i]    = step_reg[i];
            elapsed_next[i] = elapsed_reg[i];
            inc             = (elapsed_reg[i] == ELAPSED_MAX) ? elapsed_reg[i]
                                                                : elapsed_reg[i] + 1'b1;
            toggle          = enabled_reg[i] && (inc > hp_reg[i]);
            if (is_tick)
            begin
                elapsed_next[i] = toggle ? '0 : inc;
                step_next[i]    = step_reg[i] ^ toggle;
            end
            if (apply && sel_mask[i])
            begin
                enabled_next[i] = (speed != '0);
                dir_next[i]     = !reverse_reg;
            end
        end
    end

    // Result composition; lines beyond the motor count read zero
    for (genvar j = 0; j < OUT_LINES; j++)
    begin : g_lines
        if (j < MOTOR_COUNT)
        begin : g_used
            assign out_item_next.step_lines[j]     = step_next[j];
            assign out_item_next.dir_lines[j]      = dir_next[j];
            assign out_item_next.enable_lines_n[j] = !enabled_next[j];
        end
        else
        begin : g_unused
            assign out_item_next.step_lines[j]     = 1'b0;
            assign out_item_next.dir_lines[j]      = 1'b0;
            assign out_item_next.enable_lines_n[j] = 1'b0;
        end
    end
    assign out_item_next.frame_applied = apply;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= FAST_RESET;
            slow_reg <= SLOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FASTEST: fast_reg <= cfg_data;
                CFG_SLOWEST: slow_reg <= cfg_data;
                default:     fast_reg <= fast_reg;
            endcase
        end
    end

    // Input register: take a new item when empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (process)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    // Result register: load on process, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process)
            out_item_reg <= out_item_next;
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEEK;
            target_reg  <= '0;
            reverse_reg <= 1'b0;
            accum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (capture_motor)
            begin
                target_reg  <= dval[TGT_W-1:0];
                reverse_reg <= 1'b0;
                accum_reg   <= '0;
            end
            if (set_reverse)
                reverse_reg <= 1'b1;
            if (shift_digit)
                accum_reg <= accum_shift;
        end
    end

    // Motor registers and the two-stage half-period update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
            dir_reg     <= '1;
            step_reg    <= '0;
            pend_reg    <= 1'b0;
            mask_reg    <= '0;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                hp_reg[i]      <= DEFAULT_HALF;
                elapsed_reg[i] <= '0;
            end
        end
        else
        begin
            enabled_reg <= enabled_next;
            dir_reg     <= dir_next;
            step_reg    <= step_next;
            pend_reg    <= apply;
            if (apply)
                mask_reg <= sel_mask;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                elapsed_reg[i] <= elapsed_next[i];
                if (pend_reg && mask_reg[i])
                    hp_reg[i] <= hp_new;
            end
        end
    end

    // Hold the biased product for the divide stage
    always_ff @(posedge clk)
    begin
        if (apply)
            prod_reg <= hp_biased[23:0];
    end

endmodule

`default_nettype wire

/* sv/ascsp_checker.sv */
// Port-level checks for the stepper pulse generator, bound to the top level.
// Depends on ascsp_pkg and ascii_command_stepper_pulse_gen_top.
`default_nettype none

module ascsp_checker
(
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_stall,
    input wire                   out_valid,
    input wire                   out_stall,
    input ascsp_pkg::out_item_t  out_item
);

    import ascsp_pkg::*;

    logic                 prev_have_reg;
    logic [OUT_LINES-1:0] prev_step_reg;
    logic [OUT_LINES-1:0] prev_dir_reg;
    logic [OUT_LINES-1:0] prev_en_n_reg;
    logic                 out_take;

    assign out_take = out_valid && !out_stall;

    // Track the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_have_reg <= 1'b0;
            prev_step_reg <= '0;
            prev_dir_reg  <= '0;
            prev_en_n_reg <= '0;
        end
        else if (out_take)
        begin
            prev_have_reg <= 1'b1;
            prev_step_reg <= out_item.step_lines;
            prev_dir_reg  <= out_item.dir_lines;
            prev_en_n_reg <= out_item.enable_lines_n;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Direction and enable change only with an applied frame
    a_frame_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && prev_have_reg && !out_item.frame_applied
        |-> (out_item.dir_lines == prev_dir_reg)
            && (out_item.enable_lines_n == prev_en_n_reg))
        else $error("direction or enable changed without a frame");

    // A disabled motor keeps its step level
    a_step_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && prev_have_reg
        |-> ((out_item.step_lines ^ prev_step_reg) & prev_en_n_reg) == '0)
        else $error("step toggled on a disabled motor");

    // Input backpressure only while a result is pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind ascii_command_stepper_pulse_gen_top ascsp_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
